FILE: rtl/tfd_pkg.sv
package tfd_pkg;

   // depth of the word queue between parser and result stage
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);

   // result kinds
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_PADDING = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   // parser phases
   typedef enum logic [2:0] {
      PH_EXT   = 3'd0,
      PH_HDR   = 3'd1,
      PH_EXTRA = 3'd2,
      PH_PAY   = 3'd3,
      PH_PAD   = 3'd4,
      PH_DONE  = 3'd5
   } phase_type;

   // one result word as seen on the output port
   typedef struct packed {
      kind_type    kind;
      logic [31:0] frame_ident;
      logic [31:0] length_value;
      logic [7:0]  status_flags;
      logic [7:0]  format_flags;
      logic [31:0] unpacked_size;
      logic [7:0]  method_byte;
      logic [7:0]  group_byte;
      logic [7:0]  payload_byte;
      logic        frame_last;
   } rec_type;

   // everything one input byte causes: a parse result and an end-of-tag result
   typedef struct packed {
      logic        rec_valid;
      rec_type     rec;
      logic        fin_valid;
      logic        fin_pad;
      logic [31:0] fin_len;
   } entry_type;

endpackage

FILE: rtl/tag_frame_deframer_core.sv
// Frame walker for a version 2.3 tag body: one body byte is taken per clock cycle
// while the queue is not full, and each frame comes out as a header word followed by
// one word per payload byte, with a padding or error word where one is due. The parser
// front end updates its counters and header shift register in the cycle a byte is
// accepted and writes the resulting words into a four-deep queue; the result stage
// loads the oldest word into its output register and drains one word per cycle while
// rsp_stall is low, so the words of a byte pass through the queue and the output
// register before they are offered on the result port. The output port's single word
// per cycle sets the throughput: a byte that yields two words (a payload or header word
// plus an end-of-tag word) holds the result stage until both are taken, and req_stall
// rises only while the queue is full. There is no clearing pass after reset. The
// configuration registers unsync_enable at byte address 0 and ext_header_enable at
// address 4, bit 0 each, must be written only while the block is idle (not enforced).
module tag_frame_deframer_core (
   input  logic        clock,
   input  logic        reset,
   // input byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_tag,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_frame_ident,
   output logic [31:0] rsp_length_value,
   output logic [7:0]  rsp_status_flags,
   output logic [7:0]  rsp_format_flags,
   output logic [31:0] rsp_unpacked_size,
   output logic [7:0]  rsp_method_byte,
   output logic [7:0]  rsp_group_byte,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_frame_last,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic REG_UNSYNC = 1'b0;
   localparam logic REG_EXT    = 1'b1;

   logic               unsync_ff, unsync_in;
   logic               ext_en_ff, ext_en_in;
   logic               csr_write;
   logic               csr_index;
   logic               accept;
   logic               push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   tfd_pkg::entry_type push_entry;
   tfd_pkg::entry_type pop_entry;

   // control registers
   assign pready    = 1'b1;
   assign csr_index = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      unsync_in = unsync_ff;
      ext_en_in = ext_en_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_UNSYNC: unsync_in = pwdata[0];
            REG_EXT:    ext_en_in = pwdata[0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unsync_ff <= 1'b0;
         ext_en_ff <= 1'b0;
      end else begin
         unsync_ff <= unsync_in;
         ext_en_ff <= ext_en_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_UNSYNC: prdata = {31'd0, unsync_ff};
         REG_EXT:    prdata = {31'd0, ext_en_ff};
         default:    prdata = '0;
      endcase
   end

   // input handshake
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   tfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .end_of_tag (req_end_of_tag),
      .unsync_en  (unsync_ff),
      .ext_en     (ext_en_ff),
      .push       (push),
      .entry      (push_entry)
   );

   tfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   tfd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_entry           (pop_entry),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_frame_ident   (rsp_frame_ident),
      .rsp_length_value  (rsp_length_value),
      .rsp_status_flags  (rsp_status_flags),
      .rsp_format_flags  (rsp_format_flags),
      .rsp_unpacked_size (rsp_unpacked_size),
      .rsp_method_byte   (rsp_method_byte),
      .rsp_group_byte    (rsp_group_byte),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_frame_last    (rsp_frame_last)
   );

endmodule

FILE: rtl/tfd_front.sv
module tfd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                end_of_tag,
   input  logic                unsync_en,
   input  logic                ext_en,
   output logic                push,
   output tfd_pkg::entry_type  entry
);

   localparam int CNT_W = 33;
   localparam logic [CNT_W-1:0] EXT_SIZE_BYTES = CNT_W'(4);
   localparam logic [CNT_W-1:0] ID_BYTES       = CNT_W'(4);
   localparam logic [CNT_W-1:0] SHIFT_BYTES    = CNT_W'(8);
   localparam logic [CNT_W-1:0] FLAG_A_POS     = CNT_W'(8);
   localparam logic [CNT_W-1:0] FLAG_B_POS     = CNT_W'(9);
   localparam logic [CNT_W-1:0] HDR_BYTES      = CNT_W'(10);
   localparam logic [3:0]       BODY_MAX       = 4'd15;
   localparam logic [3:0]       CRC_POS        = 4'd4;
   localparam logic [3:0]       NEED_PLAIN     = 4'd10;
   localparam logic [3:0]       NEED_CRC       = 4'd14;
   localparam logic [31:0]      PAD_START      = 32'd4;
   localparam logic [31:0]      PAD_MAX        = 32'hFFFF_FFFF;
   localparam int               FMT_COMPRESSED = 7;
   localparam int               FMT_ENCRYPTED  = 6;
   localparam int               FMT_GROUPED    = 5;
   localparam int               CRC_BIT        = 7;

   tfd_pkg::phase_type phase_ff, phase_in;
   logic [CNT_W-1:0]   byte_cnt_ff, byte_cnt_in;
   logic [63:0]        header_shift_ff, header_shift_in;
   logic [31:0]        remaining_ff, remaining_in;
   logic               prev_was_ff_ff, prev_was_ff_in;
   logic [47:0]        extra_ff, extra_in;
   logic               zero_run_ff, zero_run_in;
   logic [3:0]         body_cnt_ff, body_cnt_in;
   logic [31:0]        pad_cnt_ff, pad_cnt_in;
   logic [31:0]        ext_len_ff, ext_len_in;
   logic               ext_active_ff, ext_active_in;
   logic               crc_ff, crc_in;
   logic [7:0]         flag_a_ff, flag_a_in;
   logic [7:0]         flag_b_ff, flag_b_in;
   logic [2:0]         extras_ff, extras_in;
   logic [31:0]        ident_ff, ident_in;

   logic               keep;
   logic               hdr_req;
   logic               nf_req;
   logic [CNT_W-1:0]   bcn;
   logic [31:0]        size;
   logic [2:0]         k;
   logic [2:0]         slot;
   logic               j_zero;
   logic [3:0]         need;

   // number of extra header bytes that the format flags announce
   function automatic logic [2:0] extras_of(input logic [7:0] fb);
      logic [2:0] n;
      n = (fb[FMT_COMPRESSED] ? 3'd4 : 3'd0) + (fb[FMT_ENCRYPTED] ? 3'd1 : 3'd0)
          + (fb[FMT_GROUPED] ? 3'd1 : 3'd0);
      return n;
   endfunction

   // frame header word, with absent extras forced to zero
   function automatic tfd_pkg::rec_type make_header(input logic [31:0] ident,
                                                    input logic [31:0] rem,
                                                    input logic [7:0]  fa,
                                                    input logic [7:0]  fb,
                                                    input logic [47:0] ext);
      tfd_pkg::rec_type r;
      r               = '0;
      r.kind          = tfd_pkg::KIND_HEADER;
      r.frame_ident   = ident;
      r.length_value  = rem;
      r.status_flags  = fa;
      r.format_flags  = fb;
      r.unpacked_size = fb[FMT_COMPRESSED] ? ext[47:16] : 32'd0;
      r.method_byte   = fb[FMT_ENCRYPTED] ? ext[15:8] : 8'd0;
      r.group_byte    = fb[FMT_GROUPED] ? ext[7:0] : 8'd0;
      r.frame_last    = (rem == 32'd0);
      return r;
   endfunction

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= tfd_pkg::PH_HDR;
         byte_cnt_ff     <= '0;
         header_shift_ff <= '0;
         remaining_ff    <= '0;
         prev_was_ff_ff  <= 1'b0;
         extra_ff        <= '0;
         zero_run_ff     <= 1'b1;
         body_cnt_ff     <= '0;
         pad_cnt_ff      <= '0;
         ext_len_ff      <= '0;
         ext_active_ff   <= 1'b0;
         crc_ff          <= 1'b0;
         flag_a_ff       <= '0;
         flag_b_ff       <= '0;
         extras_ff       <= '0;
         ident_ff        <= '0;
      end else begin
         phase_ff        <= phase_in;
         byte_cnt_ff     <= byte_cnt_in;
         header_shift_ff <= header_shift_in;
         remaining_ff    <= remaining_in;
         prev_was_ff_ff  <= prev_was_ff_in;
         extra_ff        <= extra_in;
         zero_run_ff     <= zero_run_in;
         body_cnt_ff     <= body_cnt_in;
         pad_cnt_ff      <= pad_cnt_in;
         ext_len_ff      <= ext_len_in;
         ext_active_ff   <= ext_active_in;
         crc_ff          <= crc_in;
         flag_a_ff       <= flag_a_in;
         flag_b_ff       <= flag_b_in;
         extras_ff       <= extras_in;
         ident_ff        <= ident_in;
      end
   end

   // byte filter, frame walk and end-of-tag check
   always_comb begin
      phase_in        = phase_ff;
      byte_cnt_in     = byte_cnt_ff;
      header_shift_in = header_shift_ff;
      remaining_in    = remaining_ff;
      prev_was_ff_in  = prev_was_ff_ff;
      extra_in        = extra_ff;
      zero_run_in     = zero_run_ff;
      body_cnt_in     = body_cnt_ff;
      pad_cnt_in      = pad_cnt_ff;
      ext_len_in      = ext_len_ff;
      ext_active_in   = ext_active_ff;
      crc_in          = crc_ff;
      flag_a_in       = flag_a_ff;
      flag_b_in       = flag_b_ff;
      extras_in       = extras_ff;
      ident_in        = ident_ff;
      entry           = '0;
      keep            = 1'b0;
      hdr_req         = 1'b0;
      nf_req          = 1'b0;
      bcn             = byte_cnt_ff + CNT_W'(1);
      size            = header_shift_ff[31:0];
      k               = byte_cnt_ff[2:0];
      slot            = 3'd5 - k;
      j_zero          = flag_b_ff[FMT_COMPRESSED] ? (k == 3'd4) : (k == 3'd0);
      need            = NEED_PLAIN;

      if (accept) begin
         // unsynchronisation: drop a zero after a kept 0xff
         if (unsync_en && prev_was_ff_ff && (data_byte == 8'h00)) begin
            keep           = 1'b0;
            prev_was_ff_in = 1'b0;
         end else begin
            keep           = 1'b1;
            prev_was_ff_in = (data_byte == 8'hFF);
         end

         if (keep) begin
            // first kept byte of a tag samples the extended header enable
            if (body_cnt_ff == 4'd0) begin
               ext_active_in = ext_en;
               phase_in      = ext_en ? tfd_pkg::PH_EXT : tfd_pkg::PH_HDR;
            end
            if (ext_active_in && (body_cnt_ff == CRC_POS)) begin
               crc_in = data_byte[CRC_BIT];
            end
            if (body_cnt_ff != BODY_MAX) begin
               body_cnt_in = body_cnt_ff + 4'd1;
            end

            unique case (phase_in)
               tfd_pkg::PH_EXT: begin
                  if (byte_cnt_ff < EXT_SIZE_BYTES) begin
                     ext_len_in = {ext_len_ff[23:0], data_byte};
                  end
                  byte_cnt_in = bcn;
                  if ((bcn >= EXT_SIZE_BYTES) && (bcn >= ({1'b0, ext_len_in} + EXT_SIZE_BYTES)))
                  begin
                     nf_req = 1'b1;
                  end
               end
               tfd_pkg::PH_HDR: begin
                  if (byte_cnt_ff < SHIFT_BYTES) begin
                     header_shift_in = {header_shift_ff[55:0], data_byte};
                  end
                  if ((byte_cnt_ff < ID_BYTES) && (data_byte != 8'h00)) begin
                     zero_run_in = 1'b0;
                  end
                  if (byte_cnt_ff == FLAG_A_POS) begin
                     flag_a_in = data_byte;
                  end
                  if (byte_cnt_ff == FLAG_B_POS) begin
                     flag_b_in = data_byte;
                  end
                  byte_cnt_in = bcn;
                  if ((bcn == ID_BYTES) && zero_run_in) begin
                     // all-zero id: padding starts here
                     phase_in   = tfd_pkg::PH_PAD;
                     pad_cnt_in = PAD_START;
                  end else if (bcn == HDR_BYTES) begin
                     size      = header_shift_in[31:0];
                     ident_in  = header_shift_in[63:32];
                     extras_in = extras_of(data_byte);
                     if (size < {29'd0, extras_in}) begin
                        entry.rec_valid = 1'b1;
                        entry.rec.kind  = tfd_pkg::KIND_ERROR;
                        phase_in        = tfd_pkg::PH_DONE;
                     end else begin
                        remaining_in = size - {29'd0, extras_in};
                        extra_in     = '0;
                        if (extras_in == 3'd0) begin
                           hdr_req = !end_of_tag;
                        end else begin
                           phase_in    = tfd_pkg::PH_EXTRA;
                           byte_cnt_in = '0;
                        end
                     end
                  end
               end
               tfd_pkg::PH_EXTRA: begin
                  // place each extra byte in its slot
                  if (flag_b_ff[FMT_COMPRESSED] && (k < 3'd4)) begin
                     extra_in = extra_ff | (48'(data_byte) << {slot, 3'b000});
                  end else if (flag_b_ff[FMT_ENCRYPTED] && j_zero) begin
                     extra_in = extra_ff | (48'(data_byte) << 8);
                  end else begin
                     extra_in = extra_ff | 48'(data_byte);
                  end
                  byte_cnt_in = bcn;
                  if (bcn >= CNT_W'(extras_ff)) begin
                     hdr_req = 1'b1;
                  end
               end
               tfd_pkg::PH_PAY: begin
                  remaining_in           = remaining_ff - 32'd1;
                  entry.rec_valid        = 1'b1;
                  entry.rec.kind         = tfd_pkg::KIND_PAYLOAD;
                  entry.rec.frame_ident  = ident_ff;
                  entry.rec.payload_byte = data_byte;
                  entry.rec.frame_last   = (remaining_in == 32'd0);
                  nf_req                 = (remaining_in == 32'd0);
               end
               tfd_pkg::PH_PAD: begin
                  if (pad_cnt_ff != PAD_MAX) begin
                     pad_cnt_in = pad_cnt_ff + 32'd1;
                  end
               end
               tfd_pkg::PH_DONE: begin
               end
               default: begin
               end
            endcase

            // header word, then on to payload or the next frame
            if (hdr_req) begin
               entry.rec_valid = 1'b1;
               entry.rec       = make_header(ident_in, remaining_in, flag_a_in, flag_b_in,
                                             extra_in);
               if (remaining_in != 32'd0) begin
                  phase_in = tfd_pkg::PH_PAY;
               end else begin
                  nf_req = 1'b1;
               end
            end
            if (nf_req) begin
               phase_in        = tfd_pkg::PH_HDR;
               byte_cnt_in     = '0;
               header_shift_in = '0;
               zero_run_in     = 1'b1;
               extra_in        = '0;
            end
         end

         // end of tag: padding report or truncation error, then clear
         if (end_of_tag) begin
            if (phase_in != tfd_pkg::PH_DONE) begin
               need = crc_in ? NEED_CRC : NEED_PLAIN;
               if (ext_active_in && (body_cnt_in < need)) begin
                  entry.fin_valid = 1'b1;
               end else if (phase_in == tfd_pkg::PH_HDR) begin
                  if (byte_cnt_in != '0) begin
                     entry.fin_valid = 1'b1;
                     if ((byte_cnt_in < ID_BYTES) && zero_run_in) begin
                        entry.fin_pad = 1'b1;
                        entry.fin_len = byte_cnt_in[31:0];
                     end
                  end
               end else if ((phase_in == tfd_pkg::PH_EXTRA) ||
                            ((phase_in == tfd_pkg::PH_PAY) && (remaining_in != 32'd0))) begin
                  entry.fin_valid = 1'b1;
               end else if (phase_in == tfd_pkg::PH_PAD) begin
                  entry.fin_valid = 1'b1;
                  entry.fin_pad   = 1'b1;
                  entry.fin_len   = pad_cnt_in;
               end
            end
            phase_in        = tfd_pkg::PH_HDR;
            byte_cnt_in     = '0;
            header_shift_in = '0;
            remaining_in    = '0;
            prev_was_ff_in  = 1'b0;
            extra_in        = '0;
            zero_run_in     = 1'b1;
            body_cnt_in     = '0;
            pad_cnt_in      = '0;
            ext_len_in      = '0;
            ext_active_in   = 1'b0;
            crc_in          = 1'b0;
            flag_a_in       = '0;
            flag_b_in       = '0;
            extras_in       = '0;
            ident_in        = '0;
         end
      end
      push = entry.rec_valid | entry.fin_valid;
   end

   // a finished tag leaves the walker ready for a fresh body
   a_tag_cleared: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_tag) |=> (phase_ff == tfd_pkg::PH_HDR) && (body_cnt_ff == 4'd0)
                                 && (byte_cnt_ff == '0))
      else $error("walker state not cleared after end of tag");

endmodule

FILE: rtl/tfd_queue.sv
module tfd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tfd_pkg::entry_type  push_entry,
   input  logic                pop,
   output tfd_pkg::entry_type  pop_entry,
   output logic                full,
   output logic                empty
);

   tfd_pkg::entry_type             slots_ff [tfd_pkg::Q_DEPTH];
   logic [tfd_pkg::Q_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tfd_pkg::Q_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tfd_pkg::Q_PTR_W:0]      count_ff, count_in;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry = slots_ff[rd_ptr_ff];
   assign full      = (count_ff == (tfd_pkg::Q_PTR_W + 1)'(tfd_pkg::Q_DEPTH));
   assign empty     = (count_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("word pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("word popped from an empty queue");

endmodule

FILE: rtl/tfd_back.sv
module tfd_back (
   input  logic                clock,
   input  logic                reset,
   input  tfd_pkg::entry_type  q_entry,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [31:0]         rsp_frame_ident,
   output logic [31:0]         rsp_length_value,
   output logic [7:0]          rsp_status_flags,
   output logic [7:0]          rsp_format_flags,
   output logic [31:0]         rsp_unpacked_size,
   output logic [7:0]          rsp_method_byte,
   output logic [7:0]          rsp_group_byte,
   output logic [7:0]          rsp_payload_byte,
   output logic                rsp_frame_last
);

   tfd_pkg::entry_type cur_ff, cur_in;
   logic               rec_pend_ff, rec_pend_in;
   logic               fin_pend_ff, fin_pend_in;
   logic               take;
   tfd_pkg::rec_type   out_rec;

   // hand out the parse word first, then the end-of-tag word
   always_comb begin
      take        = rsp_valid && !rsp_stall;
      cur_in      = cur_ff;
      rec_pend_in = rec_pend_ff;
      fin_pend_in = fin_pend_ff;
      if (take) begin
         if (rec_pend_ff) begin
            rec_pend_in = 1'b0;
         end else begin
            fin_pend_in = 1'b0;
         end
      end
      q_pop = !rec_pend_in && !fin_pend_in && !q_empty;
      if (q_pop) begin
         cur_in      = q_entry;
         rec_pend_in = q_entry.rec_valid;
         fin_pend_in = q_entry.fin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_pend_ff <= 1'b0;
         fin_pend_ff <= 1'b0;
      end else begin
         rec_pend_ff <= rec_pend_in;
         fin_pend_ff <= fin_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // output word selection
   always_comb begin
      out_rec = '0;
      if (rec_pend_ff) begin
         out_rec = cur_ff.rec;
      end else if (cur_ff.fin_pad) begin
         out_rec.kind         = tfd_pkg::KIND_PADDING;
         out_rec.length_value = cur_ff.fin_len;
      end else begin
         out_rec.kind = tfd_pkg::KIND_ERROR;
      end
   end

   assign rsp_valid         = rec_pend_ff | fin_pend_ff;
   assign rsp_kind          = out_rec.kind;
   assign rsp_frame_ident   = out_rec.frame_ident;
   assign rsp_length_value  = out_rec.length_value;
   assign rsp_status_flags  = out_rec.status_flags;
   assign rsp_format_flags  = out_rec.format_flags;
   assign rsp_unpacked_size = out_rec.unpacked_size;
   assign rsp_method_byte   = out_rec.method_byte;
   assign rsp_group_byte    = out_rec.group_byte;
   assign rsp_payload_byte  = out_rec.payload_byte;
   assign rsp_frame_last    = out_rec.frame_last;

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == tfd_pkg::KIND_ERROR)) |->
         (rsp_frame_ident == 32'd0) && (rsp_length_value == 32'd0) &&
         (rsp_unpacked_size == 32'd0) && (rsp_payload_byte == 8'd0) && !rsp_frame_last)
      else $error("error word carries non-zero fields");

   a_empty_frame_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == tfd_pkg::KIND_HEADER) && rsp_frame_last) |->
         (rsp_length_value == 32'd0))
      else $error("header marked last with payload pending");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   // register addresses on the configuration port
   localparam logic [2:0] REG_UNSYNC_ADDR = 3'd0;
   localparam logic [2:0] REG_EXT_ADDR    = 3'd4;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PRINT_CAP    = 50;

   typedef struct packed {
      logic [7:0] data;
      logic       eot;
   } in_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_tag = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_frame_ident;
   logic [31:0] rsp_length_value;
   logic [7:0]  rsp_status_flags;
   logic [7:0]  rsp_format_flags;
   logic [31:0] rsp_unpacked_size;
   logic [7:0]  rsp_method_byte;
   logic [7:0]  rsp_group_byte;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_frame_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   tag_frame_deframer_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_tag    (req_end_of_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_frame_ident   (rsp_frame_ident),
      .rsp_length_value  (rsp_length_value),
      .rsp_status_flags  (rsp_status_flags),
      .rsp_format_flags  (rsp_format_flags),
      .rsp_unpacked_size (rsp_unpacked_size),
      .rsp_method_byte   (rsp_method_byte),
      .rsp_group_byte    (rsp_group_byte),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_frame_last    (rsp_frame_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // clock, 20 ns period
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // stimulus and expectation stores
   in_word_type       pending_words[$];
   tfd_pkg::rec_type  expected_words[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int words_checked = 0;
   int bytes_queued = 0;
   int tags_queued = 0;
   int csr_writes = 0;
   int cycle_count = 0;

   // walker state mirrored from the block
   logic               cfg_unsync;
   logic               cfg_ext;
   tfd_pkg::phase_type wk_phase;
   logic [63:0]        wk_count;
   logic [63:0]        hdr_sr;
   logic [31:0]        pay_left;
   logic               last_ff;
   logic [63:0]        extra_sr;
   logic               id_zero;
   logic               walk_over;
   logic [31:0]        body_seen;
   logic [31:0]        pad_len;
   logic [63:0]        ext_size;
   logic               ext_on;
   logic               crc_on;
   logic [7:0]         flags_st;
   logic [7:0]         flags_fmt;
   logic [31:0]        extra_need;
   logic [31:0]        ident_cur;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_CAP)
         $display("mismatch at word %0d: %s got %h want %h", words_checked, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // append one word to the expectation store
   function automatic void expect_word(input tfd_pkg::rec_type w);
      expected_words.insert(expected_words.size(), w);
   endfunction

   // back to the start-of-tag state
   function automatic void tag_reset();
      wk_phase   = tfd_pkg::PH_HDR;
      wk_count   = '0;
      hdr_sr     = '0;
      pay_left   = '0;
      last_ff    = 1'b0;
      extra_sr   = '0;
      id_zero    = 1'b1;
      walk_over  = 1'b0;
      body_seen  = '0;
      pad_len    = '0;
      ext_size   = '0;
      ext_on     = 1'b0;
      crc_on     = 1'b0;
      flags_st   = '0;
      flags_fmt  = '0;
      extra_need = '0;
      ident_cur  = '0;
   endfunction

   function automatic void frame_restart();
      wk_phase = tfd_pkg::PH_HDR;
      wk_count = '0;
      hdr_sr   = '0;
      id_zero  = 1'b1;
      extra_sr = '0;
   endfunction

   function automatic void push_error();
      tfd_pkg::rec_type w;
      w = '0;
      w.kind = tfd_pkg::KIND_ERROR;
      expect_word(w);
      walk_over = 1'b1;
      wk_phase  = tfd_pkg::PH_DONE;
   endfunction

   function automatic void push_padding(input logic [31:0] count);
      tfd_pkg::rec_type w;
      w = '0;
      w.kind = tfd_pkg::KIND_PADDING;
      w.length_value = count;
      expect_word(w);
   endfunction

   function automatic void header_out();
      tfd_pkg::rec_type w;
      w = '0;
      w.kind          = tfd_pkg::KIND_HEADER;
      w.frame_ident   = ident_cur;
      w.length_value  = pay_left;
      w.status_flags  = flags_st;
      w.format_flags  = flags_fmt;
      w.unpacked_size = flags_fmt[7] ? extra_sr[47:16] : 32'h0;
      w.method_byte   = flags_fmt[6] ? extra_sr[15:8] : 8'h00;
      w.group_byte    = flags_fmt[5] ? extra_sr[7:0] : 8'h00;
      w.frame_last    = (pay_left == 0);
      expect_word(w);
      if (pay_left != 0)
         wk_phase = tfd_pkg::PH_PAY;
      else
         frame_restart();
   endfunction

   // expected words for one accepted body byte
   function automatic void walk_byte(input logic [7:0] b, input logic last);
      logic             keep;
      logic [31:0]      need;
      logic [31:0]      size;
      logic [31:0]      k;
      logic [31:0]      j;
      tfd_pkg::rec_type w;
      keep = 1'b1;
      // unsync: a zero straight after a kept 0xFF is dropped
      if (cfg_unsync && last_ff && b == 8'h00) begin
         keep = 1'b0;
         last_ff = 1'b0;
      end else begin
         last_ff = (b == 8'hFF);
      end
      if (keep) begin
         if (body_seen == 0) begin
            ext_on = cfg_ext;
            wk_phase = ext_on ? tfd_pkg::PH_EXT : tfd_pkg::PH_HDR;
         end
         if (ext_on && body_seen == 4)
            crc_on = b[7];
         if (body_seen != 32'hFFFF_FFFF)
            body_seen++;
         case (wk_phase)
            tfd_pkg::PH_EXT: begin
               if (wk_count < 4)
                  ext_size = {32'h0, ext_size[23:0], b};
               wk_count++;
               if (wk_count >= 4 && wk_count >= ext_size + 4)
                  frame_restart();
            end
            tfd_pkg::PH_HDR: begin
               if (wk_count < 8)
                  hdr_sr = {hdr_sr[55:0], b};
               if (wk_count < 4 && b != 8'h00)
                  id_zero = 1'b0;
               if (wk_count == 8)
                  flags_st = b;
               if (wk_count == 9)
                  flags_fmt = b;
               wk_count++;
               if (wk_count == 4 && id_zero) begin
                  wk_phase  = tfd_pkg::PH_PAD;
                  walk_over = 1'b1;
                  pad_len   = 32'd4;
               end else if (wk_count == 10) begin
                  size       = hdr_sr[31:0];
                  ident_cur  = hdr_sr[63:32];
                  extra_need = (flags_fmt[7] ? 32'd4 : 32'd0) + (flags_fmt[6] ? 32'd1 : 32'd0)
                             + (flags_fmt[5] ? 32'd1 : 32'd0);
                  if (size < extra_need) begin
                     push_error();
                  end else begin
                     pay_left = size - extra_need;
                     extra_sr = '0;
                     if (extra_need == 0) begin
                        if (!last)
                           header_out();
                     end else begin
                        wk_phase = tfd_pkg::PH_EXTRA;
                        wk_count = '0;
                     end
                  end
               end
            end
            tfd_pkg::PH_EXTRA: begin
               k = wk_count[31:0];
               j = flags_fmt[7] ? k - 32'd4 : k;
               if (flags_fmt[7] && k < 4)
                  extra_sr = extra_sr | (64'(b) << (16 + 8 * (3 - k)));
               else if (flags_fmt[6] && j == 0)
                  extra_sr = extra_sr | (64'(b) << 8);
               else
                  extra_sr = extra_sr | 64'(b);
               wk_count++;
               if (wk_count >= extra_need)
                  header_out();
            end
            tfd_pkg::PH_PAY: begin
               pay_left--;
               w = '0;
               w.kind         = tfd_pkg::KIND_PAYLOAD;
               w.frame_ident  = ident_cur;
               w.payload_byte = b;
               w.frame_last   = (pay_left == 0);
               expect_word(w);
               if (pay_left == 0)
                  frame_restart();
            end
            tfd_pkg::PH_PAD: begin
               if (pad_len != 32'hFFFF_FFFF)
                  pad_len++;
            end
            default: begin
            end
         endcase
      end
      // end of tag: padding, short-tag error or nothing
      if (last) begin
         if (!(walk_over && wk_phase == tfd_pkg::PH_DONE)) begin
            need = crc_on ? 32'd14 : 32'd10;
            if (ext_on && body_seen < need) begin
               push_error();
            end else if (wk_phase == tfd_pkg::PH_HDR) begin
               if (wk_count != 0) begin
                  if (wk_count <= 3 && id_zero)
                     push_padding(wk_count[31:0]);
                  else
                     push_error();
               end
            end else if (wk_phase == tfd_pkg::PH_EXTRA ||
                         (wk_phase == tfd_pkg::PH_PAY && pay_left != 0)) begin
               push_error();
            end else if (wk_phase == tfd_pkg::PH_PAD) begin
               push_padding(pad_len);
            end
         end
         tag_reset();
      end
   endfunction

   // driver: one body byte per accepted word, gaps at random
   always @(posedge clock) begin : drive
      in_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            walk_byte(req_data_byte, req_end_of_tag);
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word = pending_words.pop_front();
               req_valid      <= 1'b1;
               req_data_byte  <= next_word.data;
               req_end_of_tag <= next_word.eot;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted result word with the oldest expectation
   always @(posedge clock) begin : watch
      tfd_pkg::rec_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("word with nothing expected, kind", 32'(rsp_kind), 32'h0);
            end else begin
               want = expected_words.pop_front();
               check_field("kind", 32'(rsp_kind), 32'(want.kind));
               check_field("frame_ident", rsp_frame_ident, want.frame_ident);
               check_field("length_value", rsp_length_value, want.length_value);
               check_field("status_flags", 32'(rsp_status_flags), 32'(want.status_flags));
               check_field("format_flags", 32'(rsp_format_flags), 32'(want.format_flags));
               check_field("unpacked_size", rsp_unpacked_size, want.unpacked_size);
               check_field("method_byte", 32'(rsp_method_byte), 32'(want.method_byte));
               check_field("group_byte", 32'(rsp_group_byte), 32'(want.group_byte));
               check_field("payload_byte", 32'(rsp_payload_byte), 32'(want.payload_byte));
               check_field("frame_last", 32'(rsp_frame_last), 32'(want.frame_last));
            end
            words_checked++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                  expected_words.size());
         $display("simulation failed");
         $finish;
      end
   end

   // register write followed by a read back
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == REG_UNSYNC_ADDR)
         cfg_unsync = value[0];
      else if (addr == REG_EXT_ADDR)
         cfg_ext = value[0];
      csr_writes++;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      if (prdata !== value)
         report_mismatch("register read back", prdata, value);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // wait until nothing is in flight, then let the pipeline settle
   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_tag(input logic [7:0] body[$]);
      in_word_type w;
      foreach (body[i]) begin
         w.data = body[i];
         w.eot  = (i == body.size() - 1);
         pending_words.insert(pending_words.size(), w);
      end
      bytes_queued += body.size();
      tags_queued++;
   endtask

   // mostly well-formed tag with random content and a random ending
   task automatic random_tag(input logic with_unsync, input logic with_ext);
      logic [7:0]  body[$];
      logic [7:0]  raw[$];
      logic [31:0] field;
      logic [7:0]  fmt;
      int          nfr;
      int          plen;
      int          extras;
      int          ending;
      int          cut_max;
      // extended header: usually short and complete, sometimes running past the end
      if (with_ext) begin
         if ($urandom_range(9) == 0)
            field = $urandom;
         else
            field = $urandom_range(0, 6);
         for (int i = 3; i >= 0; i--)
            body.insert(body.size(), field[8*i +: 8]);
         if (field <= 6)
            repeat (field) body.insert(body.size(), 8'($urandom));
         else
            repeat ($urandom_range(0, 8)) body.insert(body.size(), 8'($urandom));
      end
      nfr = $urandom_range(0, 3);
      repeat (nfr) begin
         field = $urandom;
         if ($urandom_range(3) != 0)
            field[31:24] = 8'($urandom_range(65, 90));
         for (int i = 3; i >= 0; i--)
            body.insert(body.size(), field[8*i +: 8]);
         fmt = 8'($urandom);
         extras = (fmt[7] ? 4 : 0) + (fmt[6] ? 1 : 0) + (fmt[5] ? 1 : 0);
         plen = $urandom_range(0, 5);
         field = extras + plen;
         if (extras != 0 && $urandom_range(11) == 0)
            field = $urandom_range(0, extras - 1);
         else if ($urandom_range(15) == 0)
            field = $urandom;
         for (int i = 3; i >= 0; i--)
            body.insert(body.size(), field[8*i +: 8]);
         body.insert(body.size(), 8'($urandom));
         body.insert(body.size(), fmt);
         repeat (extras) body.insert(body.size(), 8'($urandom));
         repeat (plen)
            body.insert(body.size(), ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom));
      end
      // ending: exact, short padding, long padding, truncated or noise
      ending = $urandom_range(0, 9);
      if (ending == 4 || ending == 5) begin
         repeat ($urandom_range(1, 3)) body.insert(body.size(), 8'h00);
      end else if (ending == 6 || ending == 7) begin
         repeat ($urandom_range(4, 12)) body.insert(body.size(), 8'h00);
      end else if (ending == 8 && body.size() > 1) begin
         cut_max = (body.size() > 8) ? 8 : body.size() - 1;
         repeat ($urandom_range(1, cut_max)) body.delete(body.size() - 1);
      end else if (ending == 9) begin
         repeat ($urandom_range(1, 12)) body.insert(body.size(), 8'($urandom));
      end
      if (body.size() == 0)
         body.insert(body.size(), 8'($urandom));
      // unsync coding: stuff a zero after most 0xFF bytes
      foreach (body[i]) begin
         raw.insert(raw.size(), body[i]);
         if (with_unsync && body[i] == 8'hFF && $urandom_range(9) != 0)
            raw.insert(raw.size(), 8'h00);
      end
      queue_tag(raw);
   endtask

   initial begin : stimulus
      logic [7:0] tmp[$];
      int         phase_start;
      logic       paused_once;
      paused_once = 1'b0;
      cfg_unsync = 1'b0;
      cfg_ext = 1'b0;
      tag_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed tags, plain coding
      wait_drained();
      csr_write(REG_UNSYNC_ADDR, 32'd0);
      csr_write(REG_EXT_ADDR, 32'd0);
      // one frame ending exactly on its boundary
      tmp = '{8'h54, 8'h49, 8'h54, 8'h32, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00,
              8'h41, 8'h42};
      queue_tag(tmp);
      // empty frame, then a short run of trailing zeros
      tmp = '{8'h54, 8'h58, 8'h58, 8'h58, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE0, 8'h1F,
              8'h00, 8'h00};
      queue_tag(tmp);
      // all-zero id: padding to the end
      tmp = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      queue_tag(tmp);
      // tag ends inside a frame header
      tmp = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h00};
      queue_tag(tmp);
      // size smaller than the extras, rest ignored
      tmp = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'hE0,
              8'h11, 8'h22};
      queue_tag(tmp);
      // all extras, then a bare 10-byte header at the end
      tmp = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h08, 8'hFF, 8'hE0,
              8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'h01, 8'h02,
              8'h43, 8'h4F, 8'h4D, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00};
      queue_tag(tmp);
      // huge size: payload byte at the end, then the error
      tmp = '{8'h41, 8'h50, 8'h49, 8'h43, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h40,
              8'h05, 8'hAA};
      queue_tag(tmp);
      // tag ends where the extras should start
      tmp = '{8'h4D, 8'h43, 8'h44, 8'h49, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h20};
      queue_tag(tmp);

      // directed tags, unsync coding and extended header
      wait_drained();
      csr_write(REG_UNSYNC_ADDR, 32'd1);
      csr_write(REG_EXT_ADDR, 32'd1);
      // tag shorter than the minimum length with an extended header
      tmp = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h42};
      queue_tag(tmp);
      // crc flag raises the minimum length
      tmp = '{8'h00, 8'h00, 8'h00, 8'h06, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h00, 8'h00};
      queue_tag(tmp);
      // extended header running past the end of the tag
      tmp = '{8'h00, 8'h00, 8'h10, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
              8'h07, 8'h08};
      queue_tag(tmp);
      // stuffed zeros in the payload, the last byte a dropped zero
      tmp = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h7F, 8'h54, 8'h49, 8'h54, 8'h32, 8'h00,
              8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h41, 8'hFF, 8'h00};
      queue_tag(tmp);

      // random tags: every register setting, every idle mix
      for (int p = 0; p < 8; p++) begin
         wait_drained();
         csr_write(REG_UNSYNC_ADDR, 32'(p[0]));
         csr_write(REG_EXT_ADDR, 32'(p[1]));
         case (p / 2)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 78;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 78;
            end
            default: begin
               send_idle_pct = 11;
               stall_pct = 11;
            end
         endcase
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < 60) begin
            random_tag(p[0], p[1]);
            // sender holds off once until the block has caught up
            if (p == 2 && !paused_once && bytes_queued - phase_start >= 30) begin
               wait_drained();
               paused_once = 1'b1;
            end
         end
      end
      wait_drained();

      $display("covered %0d tags, %0d body bytes, %0d result words checked", tags_queued,
               bytes_queued, words_checked);
      $display("all four register settings (%0d writes), idle and stall mixes up to 78%%",
               csr_writes);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: tag_frame_deframer_core.f
rtl/tfd_pkg.sv
rtl/tfd_front.sv
rtl/tfd_queue.sv
rtl/tfd_back.sv
rtl/tag_frame_deframer_core.sv
dv/tb_top.sv
